>>> rtl/core/tlv_enc_pkg.sv
// ----------------------------------------------------------------------------
// TLV encoder package
// Shared types and constants for the tag-length-value element encoder.
// ----------------------------------------------------------------------------
package tlv_enc_pkg;

    localparam int DESC_BYTES = 6;
    localparam int DESC_W     = DESC_BYTES * 8;

    localparam logic [2:0] MODE_INTEGER  = 3'd0;
    localparam logic [2:0] MODE_STRING   = 3'd1;
    localparam logic [2:0] MODE_BLOB     = 3'd2;
    localparam logic [2:0] MODE_SEQUENCE = 3'd3;
    localparam logic [2:0] MODE_PAYLOAD  = 3'd4;

    localparam logic [1:0] REG_TAG_INTEGER  = 2'd0;
    localparam logic [1:0] REG_TAG_STRING   = 2'd1;
    localparam logic [1:0] REG_TAG_BLOB     = 2'd2;
    localparam logic [1:0] REG_TAG_SEQUENCE = 2'd3;

    localparam logic [7:0] RST_TAG_INTEGER  = 8'h02;
    localparam logic [7:0] RST_TAG_STRING   = 8'h0c;
    localparam logic [7:0] RST_TAG_BLOB     = 8'h04;
    localparam logic [7:0] RST_TAG_SEQUENCE = 8'h30;

    localparam logic [7:0] TAG_NEG_FLAG   = 8'h40;
    localparam logic [7:0] LEN_LONG_FLAG  = 8'h80;

    typedef struct packed {
        logic [DESC_W-1:0] bytes;
        logic [2:0]        len;
    } desc_t;

    typedef struct packed {
        logic  valid;
        desc_t desc;
    } push_t;

endpackage

>>> rtl/core/tlv_enc_front.sv
// ----------------------------------------------------------------------------
// TLV encoder front end
// Holds the tag registers and turns each request into a byte descriptor.
// ----------------------------------------------------------------------------
module tlv_enc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [7:0]          wr_data,
    input  logic                start,
    input  logic                busy,
    input  logic [2:0]          mode,
    input  logic signed [31:0]  value,
    input  logic [7:0]          payload_byte,
    output tlv_enc_pkg::push_t  push
);

    logic [7:0]  tag_integer_reg;
    logic [7:0]  tag_string_reg;
    logic [7:0]  tag_blob_reg;
    logic [7:0]  tag_sequence_reg;

    logic [2:0]  size_n;
    logic [31:0] body;
    logic [7:0]  hdr_tag;
    logic        short_form;
    logic        mode_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_integer_reg  <= tlv_enc_pkg::RST_TAG_INTEGER;
            tag_string_reg   <= tlv_enc_pkg::RST_TAG_STRING;
            tag_blob_reg     <= tlv_enc_pkg::RST_TAG_BLOB;
            tag_sequence_reg <= tlv_enc_pkg::RST_TAG_SEQUENCE;
        end
        else if (wr_en)
        begin
            case (wr_index)
                tlv_enc_pkg::REG_TAG_INTEGER:  tag_integer_reg  <= wr_data;
                tlv_enc_pkg::REG_TAG_STRING:   tag_string_reg   <= wr_data;
                tlv_enc_pkg::REG_TAG_BLOB:     tag_blob_reg     <= wr_data;
                tlv_enc_pkg::REG_TAG_SEQUENCE: tag_sequence_reg <= wr_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (value[31] || value[30:7] == 24'd0)
            size_n = 3'd1;
        else if (value[30:16] == 15'd0)
            size_n = 3'd2;
        else if (value[30:24] == 7'd0)
            size_n = 3'd3;
        else
            size_n = 3'd4;

        case (size_n)
            3'd1:    body = {value[7:0], 24'd0};
            3'd2:    body = {value[15:0], 16'd0};
            3'd3:    body = {value[23:0], 8'd0};
            default: body = value;
        endcase

        short_form = value[31] || value[30:7] == 24'd0;

        case (mode)
            tlv_enc_pkg::MODE_STRING:   hdr_tag = tag_string_reg;
            tlv_enc_pkg::MODE_BLOB:     hdr_tag = tag_blob_reg;
            default:                    hdr_tag = tag_sequence_reg;
        endcase

        mode_ok    = 1'b1;
        push.desc  = '0;
        case (mode)
            tlv_enc_pkg::MODE_INTEGER:
            begin
                push.desc.bytes = {(value[31] ? (tag_integer_reg | tlv_enc_pkg::TAG_NEG_FLAG)
                                              : tag_integer_reg),
                                   {5'd0, size_n}, body};
                push.desc.len   = 3'd2 + size_n;
            end
            tlv_enc_pkg::MODE_STRING,
            tlv_enc_pkg::MODE_BLOB,
            tlv_enc_pkg::MODE_SEQUENCE:
            begin
                if (short_form)
                begin
                    push.desc.bytes = {hdr_tag, value[7:0], 32'd0};
                    push.desc.len   = 3'd2;
                end
                else
                begin
                    push.desc.bytes = {hdr_tag, (tlv_enc_pkg::LEN_LONG_FLAG | {5'd0, size_n}),
                                       body};
                    push.desc.len   = 3'd2 + size_n;
                end
            end
            tlv_enc_pkg::MODE_PAYLOAD:
            begin
                push.desc.bytes = {payload_byte, 40'd0};
                push.desc.len   = 3'd1;
            end
            default:
            begin
                mode_ok = 1'b0;
            end
        endcase

        // drop undefined modes
        push.valid = start && !busy && mode_ok;
    end

endmodule

>>> rtl/core/tlv_enc_queue.sv
// ----------------------------------------------------------------------------
// TLV encoder descriptor queue
// Small FIFO of byte descriptors between front end and serializer.
// ----------------------------------------------------------------------------
module tlv_enc_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tlv_enc_pkg::push_t  push,
    input  logic                pop,
    output tlv_enc_pkg::desc_t  head,
    output logic                empty,
    output logic                full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tlv_enc_pkg::desc_t slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push.valid && !pop)
            count_next = count_reg + 1'b1;
        else if (!push.valid && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            slot_reg[wr_ptr_reg] <= push.desc;
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));

`ifndef ASSERT_OFF
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (!full || pop))
        else $error("queue pushed while full");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

>>> rtl/core/tlv_enc_back.sv
// ----------------------------------------------------------------------------
// TLV encoder serializer
// Takes descriptors from the queue and emits their bytes, one per cycle.
// ----------------------------------------------------------------------------
module tlv_enc_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  tlv_enc_pkg::desc_t  head,
    input  logic                empty,
    output logic                pop,
    output logic                strobe,
    output logic [7:0]          out_byte,
    output logic                last
);

    logic [tlv_enc_pkg::DESC_W-1:0] cur_bytes_reg;
    logic [tlv_enc_pkg::DESC_W-1:0] cur_bytes_next;
    logic [2:0]                     cur_rem_reg;
    logic [2:0]                     cur_rem_next;
    logic                           cur_valid_reg;
    logic                           cur_valid_next;
    logic                           strobe_reg;
    logic [7:0]                     out_byte_reg;
    logic                           last_reg;

    always_comb
    begin
        // advance to the next request as the current one finishes
        pop            = !empty && (!cur_valid_reg || cur_rem_reg == 3'd1);
        cur_bytes_next = cur_bytes_reg;
        cur_rem_next   = cur_rem_reg;
        cur_valid_next = cur_valid_reg;
        if (pop)
        begin
            cur_bytes_next = head.bytes;
            cur_rem_next   = head.len;
            cur_valid_next = 1'b1;
        end
        else if (cur_valid_reg)
        begin
            cur_bytes_next = {cur_bytes_reg[tlv_enc_pkg::DESC_W-9:0], 8'd0};
            cur_rem_next   = cur_rem_reg - 3'd1;
            cur_valid_next = (cur_rem_reg != 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cur_rem_reg   <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cur_rem_reg   <= cur_rem_next;
            strobe_reg    <= cur_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_bytes_reg <= cur_bytes_next;
        out_byte_reg  <= cur_bytes_reg[tlv_enc_pkg::DESC_W-1 -: 8];
        last_reg      <= (cur_rem_reg == 3'd1);
    end

    assign strobe   = strobe_reg;
    assign out_byte = out_byte_reg;
    assign last     = last_reg;

`ifndef ASSERT_OFF
    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> cur_rem_reg != 3'd0)
        else $error("active request with no bytes left");
    a_pop_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!cur_valid_reg || cur_rem_reg == 3'd1))
        else $error("request loaded before current one finished");
    a_more_after_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !last_reg) |-> cur_valid_reg)
        else $error("request ended without a last byte");
`endif

endmodule

>>> rtl/core/tlv_element_encoder_unit.sv
// ----------------------------------------------------------------------------
// TLV element encoder
// Serializes integer, header and payload requests into a tag-length-value
// byte stream, one byte per cycle.
// ----------------------------------------------------------------------------
// A taken request goes through the queue, the current-request register and the
// output register. Throughput: one output byte per cycle; a request of k bytes
// (1 to 6) holds the serializer for all k; payloads sustain one per cycle.
// busy rises while the descriptor queue (QUEUE_DEPTH entries) is full.
// Reset clears the queue and serializer and restores the default tags.
module tlv_element_encoder_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [7:0]         wr_data,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         mode,
    input  logic signed [31:0] value,
    input  logic [7:0]         payload_byte,
    output logic               strobe,
    output logic [7:0]         out_byte,
    output logic               last
);

    tlv_enc_pkg::push_t push;
    tlv_enc_pkg::desc_t head;
    logic               empty;
    logic               full;
    logic               pop;

    assign busy = full;

    tlv_enc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .value        (value),
        .payload_byte (payload_byte),
        .push         (push)
    );

    tlv_enc_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .empty (empty),
        .full  (full)
    );

    tlv_enc_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .strobe   (strobe),
        .out_byte (out_byte),
        .last     (last)
    );

endmodule

>>> bench/tlv_element_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV element stream checker
// Watches the tag-register port, the request port and the byte stream of
// the encoder. Predicts the encoded bytes of every accepted request from its
// own copy of the tag registers and compares each strobed byte, in order,
// with the oldest predicted byte.
// ----------------------------------------------------------------------------
module tlv_element_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [7:0]         wr_data,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         mode,
    input  logic signed [31:0] value,
    input  logic [7:0]         payload_byte,
    input  logic               strobe,
    input  logic [7:0]         out_byte,
    input  logic               last,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } tlv_byte_t;

    tlv_byte_t  expected_bytes[$];
    logic [7:0] tag_integer;
    logic [7:0] tag_string;
    logic [7:0] tag_blob;
    logic [7:0] tag_sequence;
    int         mismatches;

    function automatic int size_in_bytes(input logic signed [31:0] v);
        if (v <= 127)
            return 1;
        if (v <= 65535)
            return 2;
        if (v <= 16777215)
            return 3;
        return 4;
    endfunction

    function automatic void push_byte(input logic [7:0] data, input logic is_last);
        tlv_byte_t b;
        b.data = data;
        b.last = is_last;
        expected_bytes.push_back(b);
    endfunction

    function automatic void push_big_endian(input logic [31:0] raw, input int n);
        for (int i = n; i > 0; i--)
            push_byte(raw[8*(i-1) +: 8], i == 1);
    endfunction

    function automatic void push_encoding(
        input logic [2:0]         m,
        input logic signed [31:0] v,
        input logic [7:0]         pb
    );
        int         n;
        logic [7:0] tag;
        n = size_in_bytes(v);
        case (m)
            tlv_enc_pkg::MODE_INTEGER:
            begin
                tag = (v < 0) ? (tag_integer | tlv_enc_pkg::TAG_NEG_FLAG) : tag_integer;
                push_byte(tag, 1'b0);
                push_byte(8'(n), 1'b0);
                push_big_endian(v, n);
            end
            tlv_enc_pkg::MODE_STRING, tlv_enc_pkg::MODE_BLOB, tlv_enc_pkg::MODE_SEQUENCE:
            begin
                tag = (m == tlv_enc_pkg::MODE_STRING) ? tag_string :
                      (m == tlv_enc_pkg::MODE_BLOB)   ? tag_blob   : tag_sequence;
                push_byte(tag, 1'b0);
                if (v <= 127)
                begin
                    push_byte(v[7:0], 1'b1);
                end
                else
                begin
                    push_byte(tlv_enc_pkg::LEN_LONG_FLAG | 8'(n), 1'b0);
                    push_big_endian(v, n);
                end
            end
            tlv_enc_pkg::MODE_PAYLOAD:
            begin
                push_byte(pb, 1'b1);
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tlv_byte_t exp_b;
        if (!rst_n)
        begin
            tag_integer  = tlv_enc_pkg::RST_TAG_INTEGER;
            tag_string   = tlv_enc_pkg::RST_TAG_STRING;
            tag_blob     = tlv_enc_pkg::RST_TAG_BLOB;
            tag_sequence = tlv_enc_pkg::RST_TAG_SEQUENCE;
            expected_bytes.delete();
            mismatches = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (start && !busy)
                push_encoding(mode, value, payload_byte);
            if (wr_en)
            begin
                case (wr_index)
                    tlv_enc_pkg::REG_TAG_INTEGER:  tag_integer  = wr_data;
                    tlv_enc_pkg::REG_TAG_STRING:   tag_string   = wr_data;
                    tlv_enc_pkg::REG_TAG_BLOB:     tag_blob     = wr_data;
                    tlv_enc_pkg::REG_TAG_SEQUENCE: tag_sequence = wr_data;
                    default:          ;
                endcase
            end
            if (strobe)
            begin
                if (expected_bytes.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected byte %02h last %0b", $realtime,
                                 out_byte, last);
                    mismatches++;
                end
                else
                begin
                    exp_b = expected_bytes.pop_front();
                    if (out_byte !== exp_b.data || last !== exp_b.last)
                    begin
                        if (mismatches < 10)
                            $display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
                                     $realtime, exp_b.data, exp_b.last, out_byte, last);
                        mismatches++;
                    end
                end
            end
            errors  <= mismatches;
            pending <= expected_bytes.size();
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV element encoder testbench
// Drives directed and random integer, header and payload requests in bursts
// with random gaps, under several tag register settings, and hands the byte
// stream to the checker, which predicts and compares every encoded byte.
// ----------------------------------------------------------------------------
module testbench;

    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_TICKS = 16;
    localparam int PHASE_ITEMS  = 70;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               wr_en;
    logic [1:0]         wr_index;
    logic [7:0]         wr_data;
    logic               start;
    logic               busy;
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic [7:0]         payload_byte;
    logic               strobe;
    logic [7:0]         out_byte;
    logic               last;
    int                 errors;
    int                 pending;
    int                 burst_left = 0;
    int                 idle_cycles = 0;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    tlv_element_encoder_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .value        (value),
        .payload_byte (payload_byte),
        .strobe       (strobe),
        .out_byte     (out_byte),
        .last         (last)
    );

    tlv_element_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .value        (value),
        .payload_byte (payload_byte),
        .strobe       (strobe),
        .out_byte     (out_byte),
        .last         (last),
        .errors       (errors),
        .pending      (pending)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe || wr_en)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // hold the request until taken; drop start only between bursts
    task automatic send_request(
        input logic [2:0]         m,
        input logic signed [31:0] v,
        input logic [7:0]         pb
    );
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
        end
        start        <= 1'b1;
        mode         <= m;
        value        <= v;
        payload_byte <= pb;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic drain;
        start <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic set_tags(
        input logic [7:0] t_int,
        input logic [7:0] t_str,
        input logic [7:0] t_blob,
        input logic [7:0] t_seq
    );
        wr_en    <= 1'b1;
        wr_index <= tlv_enc_pkg::REG_TAG_INTEGER;
        wr_data  <= t_int;
        @(posedge clk);
        wr_index <= tlv_enc_pkg::REG_TAG_STRING;
        wr_data  <= t_str;
        @(posedge clk);
        wr_index <= tlv_enc_pkg::REG_TAG_BLOB;
        wr_data  <= t_blob;
        @(posedge clk);
        wr_index <= tlv_enc_pkg::REG_TAG_SEQUENCE;
        wr_data  <= t_seq;
        @(posedge clk);
        wr_en    <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_value();
        logic [31:0] edges[14];
        edges = '{32'h0, 32'h7f, 32'h80, 32'hff, 32'h100, 32'hffff, 32'h10000,
                  32'hffffff, 32'h1000000, 32'h7fffffff, 32'h80000000,
                  32'hffffffff, 32'hffffff80, 32'hffffff7f};
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 127);
            1:       return {1'b1, 31'($urandom)};
            2:       return $urandom_range(128, 255);
            3:       return $urandom_range(256, 32'h0000ffff);
            4:       return $urandom_range(32'h00010000, 32'h00ffffff);
            5:       return $urandom_range(32'h01000000, 32'h7fffffff);
            6:       return $urandom;
            default: return edges[$urandom_range(0, 13)];
        endcase
    endfunction

    function automatic logic [2:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return tlv_enc_pkg::MODE_PAYLOAD;
        if (r < 60)
            return tlv_enc_pkg::MODE_INTEGER;
        if (r < 70)
            return tlv_enc_pkg::MODE_STRING;
        if (r < 80)
            return tlv_enc_pkg::MODE_BLOB;
        if (r < 95)
            return tlv_enc_pkg::MODE_SEQUENCE;
        return 3'($urandom_range(5, 7));
    endfunction

    task automatic run_random(input int count);
        int         sent;
        logic [2:0] m;
        sent = 0;
        while (sent < count)
        begin
            m = pick_mode();
            send_request(m, pick_value(), 8'($urandom));
            if (m <= tlv_enc_pkg::MODE_PAYLOAD)
                sent++;
        end
        drain();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        wr_en        = 1'b0;
        wr_index     = tlv_enc_pkg::REG_TAG_INTEGER;
        wr_data      = 8'h00;
        start        = 1'b0;
        mode         = tlv_enc_pkg::MODE_PAYLOAD;
        value        = 32'sd0;
        payload_byte = 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(tlv_enc_pkg::MODE_INTEGER,  32'sh00000000, 8'h00);
        send_request(tlv_enc_pkg::MODE_INTEGER,  32'sh0000007f, 8'h00);
        send_request(tlv_enc_pkg::MODE_INTEGER,  32'sh00000080, 8'h00);
        send_request(tlv_enc_pkg::MODE_INTEGER,  32'sh0000ffff, 8'h00);
        send_request(tlv_enc_pkg::MODE_INTEGER,  32'sh00010000, 8'h00);
        send_request(tlv_enc_pkg::MODE_INTEGER,  32'sh00ffffff, 8'h00);
        send_request(tlv_enc_pkg::MODE_INTEGER,  32'sh01000000, 8'h00);
        send_request(tlv_enc_pkg::MODE_INTEGER,  32'sh7fffffff, 8'h00);
        send_request(tlv_enc_pkg::MODE_INTEGER,  -32'sd1,       8'h00);
        send_request(tlv_enc_pkg::MODE_INTEGER,  -32'sd128,     8'h00);
        send_request(tlv_enc_pkg::MODE_INTEGER,  32'sh80000000, 8'h00);
        send_request(tlv_enc_pkg::MODE_STRING,   32'sh00000000, 8'h00);
        send_request(tlv_enc_pkg::MODE_STRING,   32'sh0000007f, 8'h00);
        send_request(tlv_enc_pkg::MODE_BLOB,     32'sh00000080, 8'h00);
        send_request(tlv_enc_pkg::MODE_BLOB,     32'sh000000ff, 8'h00);
        send_request(tlv_enc_pkg::MODE_SEQUENCE, 32'sh00000100, 8'h00);
        send_request(tlv_enc_pkg::MODE_STRING,   32'sh00010000, 8'h00);
        send_request(tlv_enc_pkg::MODE_BLOB,     32'sh01000000, 8'h00);
        send_request(tlv_enc_pkg::MODE_SEQUENCE, 32'sh7fffffff, 8'h00);
        send_request(tlv_enc_pkg::MODE_STRING,   -32'sd1,       8'h00);
        send_request(tlv_enc_pkg::MODE_SEQUENCE, 32'sh80000000, 8'h00);
        send_request(tlv_enc_pkg::MODE_PAYLOAD,  32'sh00000000, 8'h00);
        send_request(tlv_enc_pkg::MODE_PAYLOAD,  32'shffffffff, 8'hff);
        send_request(3'd5,                       32'sh00000080, 8'h5a);
        send_request(3'd6,                       32'sh7fffffff, 8'ha5);
        send_request(3'd7,                       -32'sd1,       8'hff);
        drain();

        set_tags(8'h00, 8'h00, 8'h00, 8'h00);
        run_random(PHASE_ITEMS);
        set_tags(8'hff, 8'hff, 8'hff, 8'hff);
        run_random(PHASE_ITEMS);
        set_tags(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_random(PHASE_ITEMS);
        set_tags(8'h80, 8'h7f, 8'h40, 8'hbf);
        run_random(PHASE_ITEMS);

        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/core/tlv_enc_pkg.sv
rtl/core/tlv_enc_front.sv
rtl/core/tlv_enc_queue.sv
rtl/core/tlv_enc_back.sv
rtl/core/tlv_element_encoder_unit.sv
bench/tlv_element_checker.sv
bench/testbench.sv
